FILE: design/iht_pkg.sv
// ----------------------------------------------------------------------------
// iht_pkg
// Shared types and constants for the identifier history table.
// ----------------------------------------------------------------------------
package iht_pkg;

  localparam int HISTORY_DEPTH_DEF = 20;
  localparam int ID_W              = 32;
  localparam int TIME_W            = 31;
  localparam int SLOT_W            = 5;
  localparam int ELAPSED_W         = 32;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_QUERY  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    req_kind_t           req_type;
    logic [ID_W-1:0]     trainer_id;
    logic [TIME_W-1:0]   now_seconds;
  } request_t;

  typedef struct packed {
    logic [SLOT_W-1:0]           slot;
    logic                        found;
    logic signed [ELAPSED_W-1:0] elapsed;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

FILE: design/id_history_table_oldest_replace.sv
// ----------------------------------------------------------------------------
// id_history_table_oldest_replace
// Identifier history table with record and query requests and
// oldest-timestamp replacement.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The sequencer then
// reads the table one entry per cycle through a single memory port, tracking
// the first match, the first empty entry and the oldest entry, and reuses one
// 32-bit subtractor for the timestamp compare and for the elapsed time. The
// result beat appears on result with done high for one cycle, once the scan
// and the finish step are through. busy stays high through the scan and the
// finish step and drops in the cycle that carries the result beat, so the
// next request can be taken in that cycle but not before. The receiver
// cannot stall and must take each beat.
// ----------------------------------------------------------------------------
module id_history_table_oldest_replace #(
  parameter int HISTORY_DEPTH = iht_pkg::HISTORY_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  iht_pkg::request_t request,
  output logic              done,
  output iht_pkg::result_t  result
);

  localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  iht_pkg::state_t   state, state_next;
  iht_pkg::request_t req_q;
  iht_pkg::entry_t   cur;
  iht_pkg::entry_t   wr_entry;

  logic [CNT_W-1:0] issue_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_last;

  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [iht_pkg::TIME_W-1:0] hit_time;
  logic             emp_found;
  logic [IDX_W-1:0] emp_idx;
  logic [IDX_W-1:0] best_idx;
  logic [iht_pkg::TIME_W-1:0] best_time;

  logic             rd_en;
  logic             wr_en;
  logic             accept;
  logic             sel_final;
  logic [iht_pkg::ELAPSED_W-1:0] op_a, op_b, diff;
  logic             less;
  logic [IDX_W-1:0] fin_idx;
  logic [31:0]      slot_ext;

  assign accept   = start && !busy;
  assign cmp_last = (cmp_idx == IDX_W'(HISTORY_DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iht_pkg::ST_IDLE: begin
        if (start) state_next = iht_pkg::ST_SCAN;
      end
      iht_pkg::ST_SCAN: begin
        if (cmp_vld && cmp_last) state_next = iht_pkg::ST_FINISH;
      end
      iht_pkg::ST_FINISH: begin
        state_next = iht_pkg::ST_IDLE;
      end
      default: state_next = iht_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy      = 1'b1;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    sel_final = 1'b0;
    unique case (state)
      iht_pkg::ST_IDLE: begin
        busy = 1'b0;
      end
      iht_pkg::ST_SCAN: begin
        rd_en = (issue_cnt < CNT_W'(HISTORY_DEPTH));
      end
      iht_pkg::ST_FINISH: begin
        sel_final = 1'b1;
        wr_en     = (req_q.req_type == iht_pkg::REQ_RECORD);
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iht_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shared subtractor: timestamp compare during scan, elapsed time at finish
  assign op_a = sel_final ? {1'b0, req_q.now_seconds} : {1'b0, cur.stamp};
  assign op_b = sel_final ? {1'b0, hit_time} : {1'b0, best_time};
  assign diff = op_a - op_b;
  assign less = diff[iht_pkg::ELAPSED_W-1];

  iht_store #(
    .DEPTH(HISTORY_DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (issue_cnt[IDX_W-1:0]),
    .rd_entry (cur),
    .wr_en    (wr_en),
    .wr_addr  (fin_idx),
    .wr_entry (wr_entry)
  );

  assign wr_entry = '{id: req_q.trainer_id, stamp: req_q.now_seconds};

  // scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      cmp_vld   <= 1'b0;
      hit_found <= 1'b0;
      emp_found <= 1'b0;
    end else begin
      cmp_vld <= rd_en;
      if (accept) begin
        issue_cnt <= '0;
        hit_found <= 1'b0;
        emp_found <= 1'b0;
      end else begin
        if (rd_en) issue_cnt <= issue_cnt + CNT_W'(1);
        if (cmp_vld && !hit_found && cur.id == req_q.trainer_id) hit_found <= 1'b1;
        if (cmp_vld && !emp_found && cur.id == '0) emp_found <= 1'b1;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= request;
    end
    if (rd_en) begin
      cmp_idx <= issue_cnt[IDX_W-1:0];
    end
    if (cmp_vld) begin
      if (!hit_found && cur.id == req_q.trainer_id) begin
        hit_idx  <= cmp_idx;
        hit_time <= cur.stamp;
      end
      if (!emp_found && cur.id == '0) begin
        emp_idx <= cmp_idx;
      end
      if (cmp_idx == '0 || less) begin
        best_idx  <= cmp_idx;
        best_time <= cur.stamp;
      end
    end
  end

  // chosen entry
  always_comb begin
    if (hit_found) begin
      fin_idx = hit_idx;
    end else if (req_q.req_type == iht_pkg::REQ_QUERY) begin
      fin_idx = '0;
    end else if (emp_found) begin
      fin_idx = emp_idx;
    end else begin
      fin_idx = best_idx;
    end
  end

  assign slot_ext = 32'(fin_idx);

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sel_final;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_final) begin
      result.slot    <= slot_ext[iht_pkg::SLOT_W-1:0];
      result.found   <= hit_found;
      result.elapsed <= (req_q.req_type == iht_pkg::REQ_QUERY && hit_found) ?
                        $signed(diff) : '0;
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == iht_pkg::ST_FINISH)
    else $error("result beat without finish step");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == iht_pkg::ST_SCAN)
    else $error("accepted request did not start a scan");

  a_query_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && req_q.req_type == iht_pkg::REQ_QUERY && !result.found
    |-> result.slot == '0 && result.elapsed == '0)
    else $error("query miss with nonzero fields");

  a_record_elapsed_zero: assert property (@(posedge clk) disable iff (rst)
    done && req_q.req_type == iht_pkg::REQ_RECORD |-> result.elapsed == '0)
    else $error("record beat with nonzero elapsed");

  a_write_only_at_finish: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en && !cmp_vld)
    else $error("table write during scan");

endmodule

FILE: design/iht_store.sv
// ----------------------------------------------------------------------------
// iht_store
// Entry memory with per-entry valid bits; one write and one registered read
// per cycle, entries never written read back as zero.
// ----------------------------------------------------------------------------
module iht_store #(
  parameter int DEPTH = iht_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output iht_pkg::entry_t                       rd_entry,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  iht_pkg::entry_t                       wr_entry
);

  iht_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld;
  iht_pkg::entry_t mem_q;
  logic            vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_entry = vld_q ? mem_q : '0;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the identifier history table. Record and query
// beats are driven through start/busy. A mirror of the id and timestamp
// tables predicts each result beat, and every done beat is compared field by
// field with the oldest prediction. A short directed list covers empty
// slots, absent ids, id zero and both extremes of the elapsed time. A long
// random run then uses a small id pool, so the table fills, hits often and
// replaces the oldest entries, with ties in the timestamps.
// ----------------------------------------------------------------------------
module testbench;
  import iht_pkg::*;

  localparam int DEPTH      = HISTORY_DEPTH_DEF;
  localparam int NUM_RANDOM = 1450;
  localparam int POOL_SIZE  = 24;
  localparam int STALL_MAX  = 4000;

  class id_history_mirror;
    logic [ID_W-1:0]   ids    [DEPTH];
    logic [TIME_W-1:0] stamps [DEPTH];
    result_t           replies_due[$];
    int                mismatches;

    function new();
      foreach (ids[i]) begin
        ids[i]    = '0;
        stamps[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void apply_request(request_t req);
      int      hit;
      int      pick;
      result_t res;
      hit  = -1;
      pick = -1;
      res  = '0;
      for (int i = 0; i < DEPTH; i++)
        if (hit < 0 && ids[i] == req.trainer_id) hit = i;
      if (req.req_type == REQ_RECORD) begin
        if (hit >= 0) begin
          pick = hit;
        end else begin
          for (int i = 0; i < DEPTH; i++)
            if (pick < 0 && ids[i] == '0) pick = i;
          if (pick < 0) begin
            pick = 0;
            for (int i = 1; i < DEPTH; i++)
              if (stamps[i] < stamps[pick]) pick = i;
          end
        end
        ids[pick]    = req.trainer_id;
        stamps[pick] = req.now_seconds;
        res.slot     = SLOT_W'(pick);
        res.found    = (hit >= 0);
      end else if (hit >= 0) begin
        res.slot    = SLOT_W'(hit);
        res.found   = 1'b1;
        res.elapsed = {1'b0, req.now_seconds} - {1'b0, stamps[hit]};
      end
      replies_due.push_back(res);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        $error("result beat with nothing outstanding: slot %0d found %0d elapsed %0d",
               got.slot, got.found, $signed(got.elapsed));
        mismatches++;
        return;
      end
      want = replies_due.pop_front();
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got.slot);
        mismatches++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        mismatches++;
      end
      if (got.elapsed !== want.elapsed) begin
        $error("elapsed: expected %0d, actual %0d",
               $signed(want.elapsed), $signed(got.elapsed));
        mismatches++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  id_history_mirror mirror;
  bit               sender_idles;
  int               quiet_cycles;

  id_history_table_oldest_replace u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #1 clk = ~clk;

  // result beats cannot be held off, so take each one as it comes
  always @(posedge clk) begin
    if (!rst && done) mirror.check_reply(result);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_request(req_kind_t kind, logic [ID_W-1:0] id,
                              logic [TIME_W-1:0] now);
    int       gap;
    request_t req;
    gap = 0;
    if (sender_idles && $urandom_range(99) < 17) gap = $urandom_range(1, 30);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.req_type    = kind;
    req.trainer_id  = id;
    req.now_seconds = now;
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    mirror.apply_request(req);
    @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (mirror.replies_due.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [ID_W-1:0]   id_pool [POOL_SIZE];
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] wall;
    int                pick;

    mirror       = new();
    sender_idles = 1'b1;
    quiet_cycles = 0;
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty table: id zero hits the first empty slot, others miss
    send_request(REQ_QUERY,  32'h0000_0000, 31'd5);
    send_request(REQ_QUERY,  32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(REQ_RECORD, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    // most negative and most positive elapsed time
    send_request(REQ_QUERY,  32'hFFFF_FFFF, 31'd0);
    send_request(REQ_RECORD, 32'h0000_0001, 31'd0);
    send_request(REQ_QUERY,  32'h0000_0001, 31'h7FFF_FFFF);
    send_request(REQ_QUERY,  32'hFFFF_FFFF, 31'h7FFF_FFFF);
    // re-record refreshes the stamp in place
    send_request(REQ_RECORD, 32'hFFFF_FFFF, 31'd100);
    send_request(REQ_QUERY,  32'hFFFF_FFFF, 31'd130);
    // record of zero refreshes the first empty entry, which stays empty
    send_request(REQ_RECORD, 32'h0000_0000, 31'd77);
    send_request(REQ_QUERY,  32'h0000_0000, 31'd80);
    send_request(REQ_RECORD, 32'hA5A5_A5A5, 31'd50);
    send_request(REQ_QUERY,  32'h5A5A_5A5A, 31'd60);
    send_request(REQ_QUERY,  32'hA5A5_A5A5, 31'd49);
    drain_results();

    wall = '0;
    foreach (id_pool[i]) id_pool[i] = $urandom;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 250 == 249) foreach (id_pool[i]) id_pool[i] = $urandom;
      if (n == 700) drain_results();
      sender_idles = !(n >= 500 && n < 850);

      pick = $urandom_range(99);
      if (pick < 2) wall = '0;
      else if (pick < 4) wall = '1;
      else if (pick < 9) wall = TIME_W'($urandom);
      else wall = wall + TIME_W'($urandom_range(0, 3));

      pick = $urandom_range(99);
      if (pick < 8) id = '0;
      else if (pick < 18) id = $urandom;
      else id = id_pool[$urandom_range(POOL_SIZE - 1)];

      send_request(req_kind_t'($urandom_range(1)), id, wall);
    end

    start <= 1'b0;
    while (mirror.replies_due.size() != 0) @(negedge clk);
    repeat (DEPTH + 5) @(negedge clk);
    if (mirror.mismatches == 0 && mirror.replies_due.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
